### design/pba_pkg.sv
package pba_pkg;

    // Bitmap geometry
    localparam int MAX_PAGE_COUNT = 1024;
    localparam int WORD_W         = 32;
    localparam int WORD_CNT       = MAX_PAGE_COUNT / WORD_W;
    localparam int WORD_AW        = $clog2(WORD_CNT);
    localparam int BIT_AW         = $clog2(WORD_W);
    localparam int PAGE_W         = 10;
    localparam int COUNT_W        = 11;
    localparam int WCNT_W         = COUNT_W - BIT_AW;

    // Command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FREED     = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [PAGE_W-1:0] page_index;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [PAGE_W-1:0]  result_page;
        logic               is_set;
        logic [COUNT_W-1:0] pages_used;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic look;
        logic check;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_alloc;
        logic scan_end;
        logic idx_miss;
        logic out_free;
    } t_dp_stat;

    // Position of the lowest set bit of a bitmap word
    function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_AW-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = BIT_AW'(i);
            end
        end
        return pos;
    endfunction

endpackage

### design/page_bitmap_allocator.sv
// Channel   Valid        Stall         Payload
// request   i_in_valid   o_in_stall    i_in_req  (cmd, page_index)
// response  o_out_valid  i_out_stall   o_out_rsp (status, result_page, is_set, pages_used)
//
// Free and query go from accept through look to done (not found), or through look and check to done (page in range).
// Allocate scans the bitmap words that hold pages below the count, then goes to done:
// the bitmap RAM is read one 32-bit word per cycle until the first clear page below the count.
// Reset clears the count and the per-word valid bits; no clearing pass is needed.
// A new request is taken while the last response still waits behind i_out_stall.
module page_bitmap_allocator
    import pba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    pba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_stat    (dp_stat),
        .o_in_stall(o_in_stall),
        .o_cmd     (dp_cmd)
    );

    pba_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_req   (i_in_req),
        .i_out_stall(i_out_stall),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_out_valid(o_out_valid),
        .o_out_rsp  (o_out_rsp)
    );

endmodule

### design/pba_ram.sv
module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/pba_ctrl.sv
module pba_ctrl
    import pba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LOOK,
        S_CHECK,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall, n_in_stall;
    logic   accept;

    assign accept = i_in_valid && !r_in_stall && (r_state == S_IDLE);

    // Sequence one request at a time
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_stat.in_alloc ? S_SCAN : S_LOOK;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_LOOK: begin
                n_state = i_stat.idx_miss ? S_DONE : S_CHECK;
            end
            S_CHECK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_stall = (n_state != S_IDLE);
    end

    // Hold state and the input stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

    // Drive datapath commands
    assign o_cmd.load  = accept;
    assign o_cmd.scan  = (r_state == S_SCAN);
    assign o_cmd.look  = (r_state == S_LOOK);
    assign o_cmd.check = (r_state == S_CHECK);
    assign o_cmd.emit  = (r_state == S_DONE) && i_stat.out_free;
    assign o_in_stall  = r_in_stall;

endmodule

### design/pba_dpath.sv
module pba_dpath
    import pba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_req     i_in_req,
    input  logic     i_out_stall,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output logic     o_out_valid,
    output t_rsp     o_out_rsp
);

    logic [1:0]         r_cmd;
    logic [PAGE_W-1:0]  r_page;
    logic [COUNT_W-1:0] r_total, n_total;
    logic [WCNT_W-1:0]  r_word;
    logic               r_pend;
    logic [WORD_AW-1:0] r_pend_word;
    logic               r_pend_vld;
    logic [WORD_CNT-1:0] r_vld;
    t_rsp               r_res, n_res;
    logic               r_out_valid;
    t_rsp               r_out;

    logic [WCNT_W-1:0]  nwords;
    logic               more;
    logic [WORD_W-1:0]  ram_q;
    logic [WORD_W-1:0]  eff;
    logic [WORD_W-1:0]  lim_mask;
    logic [WORD_W-1:0]  avail;
    logic               hit;
    logic [BIT_AW-1:0]  hit_bit;
    logic               idx_miss;
    logic               page_bit;
    logic               out_free;
    logic               ram_re;
    logic [WORD_AW-1:0] ram_raddr;
    logic               ram_we;
    logic [WORD_AW-1:0] ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;

    // Words that hold pages below the count
    assign nwords = r_total[COUNT_W-1:BIT_AW] + WCNT_W'(|r_total[BIT_AW-1:0]);
    assign more   = (r_word < nwords);

    // Word under test; a never-written word reads as all clear
    assign eff      = r_pend_vld ? ram_q : '0;
    assign lim_mask = (r_total[COUNT_W-1:BIT_AW] == {1'b0, r_pend_word})
                    ? ((WORD_W'(1) << r_total[BIT_AW-1:0]) - WORD_W'(1)) : '1;
    assign avail    = ~eff & lim_mask;
    assign hit      = r_pend && (|avail);
    assign hit_bit  = lowest_set(avail);
    assign idx_miss = ({1'b0, r_page} >= r_total);
    assign page_bit = eff[r_page[BIT_AW-1:0]];
    assign out_free = !r_out_valid || !i_out_stall;

    assign ram_re    = (i_cmd.scan && more) || i_cmd.look;
    assign ram_raddr = i_cmd.look ? r_page[PAGE_W-1:BIT_AW] : r_word[WORD_AW-1:0];

    // Decide the result and the bitmap update
    always_comb begin
        n_res     = r_res;
        n_total   = r_total;
        ram_we    = 1'b0;
        ram_waddr = r_pend_word;
        ram_wdata = eff;
        if (i_cmd.scan) begin
            if (hit) begin
                ram_we    = 1'b1;
                ram_wdata = eff | (WORD_W'(1) << hit_bit);
                n_res     = '{ST_OK, {r_pend_word, hit_bit}, 1'b1, r_total};
            end else if (!more) begin
                if (r_total >= COUNT_W'(MAX_PAGE_COUNT)) begin
                    n_res = '{ST_LIMIT, r_page, 1'b0, r_total};
                end else begin
                    // every page below the count is taken: extend by one
                    n_total   = r_total + COUNT_W'(1);
                    ram_we    = 1'b1;
                    ram_waddr = r_total[PAGE_W-1:BIT_AW];
                    ram_wdata = ((WORD_W'(1) << r_total[BIT_AW-1:0]) - WORD_W'(1))
                              | (WORD_W'(1) << r_total[BIT_AW-1:0]);
                    n_res     = '{ST_OK, r_total[PAGE_W-1:0], 1'b1, n_total};
                end
            end
        end else if (i_cmd.look) begin
            if (idx_miss) begin
                n_res = '{ST_NOT_FOUND, r_page, 1'b0, r_total};
            end
        end else if (i_cmd.check) begin
            if (!page_bit) begin
                n_res = '{ST_FREED, r_page, 1'b0, r_total};
            end else if (r_cmd == CMD_FREE) begin
                ram_we    = 1'b1;
                ram_waddr = r_page[PAGE_W-1:BIT_AW];
                ram_wdata = eff & ~(WORD_W'(1) << r_page[BIT_AW-1:0]);
                n_res     = '{ST_OK, r_page, 1'b0, r_total};
            end else begin
                n_res = '{ST_OK, r_page, 1'b1, r_total};
            end
        end
    end

    pba_ram #(
        .WIDTH(WORD_W),
        .DEPTH(WORD_CNT)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    // Control state: count, word valid bits, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_vld       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_total <= n_total;
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            r_pend <= i_cmd.scan && more;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture request, advance the scan, load the output
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_cmd.load) begin
            r_cmd  <= i_in_req.cmd;
            r_page <= i_in_req.page_index;
            r_word <= '0;
        end else if (i_cmd.scan && more) begin
            r_word <= r_word + WCNT_W'(1);
        end
        if (ram_re) begin
            r_pend_word <= ram_raddr;
            r_pend_vld  <= r_vld[ram_raddr];
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_stat.in_alloc = (i_in_req.cmd == CMD_ALLOC);
    assign o_stat.scan_end = hit || !more;
    assign o_stat.idx_miss = idx_miss;
    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out_rsp       = r_out;

`ifndef NO_ASSERTIONS
    a_total_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= COUNT_W'(MAX_PAGE_COUNT))
        else $error("page count above bitmap size");

    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_total == $past(r_total)) || (r_total == $past(r_total) + COUNT_W'(1)))
        else $error("page count moved by more than one or shrank");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (i_cmd.scan || i_cmd.check))
        else $error("bitmap write outside a decision cycle");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result loaded over a waiting result");
`endif

endmodule
